// ===== src/sge_pkg.sv =====
// Shared constants and types for the Sobel gradient energy block.
package sge_pkg;

    // Default geometry and pixel depth.
    localparam int DEF_MAX_WIDTH = 2048;
    localparam int DEF_LUMA_BITS = 8;

    // Hard limits on the frame geometry.
    localparam int COL_LIMIT = 2048;
    localparam int ROW_LIMIT = 4096;
    localparam int MIN_DIM   = 3;

    // Field widths.
    localparam int LUMA_W   = 8;
    localparam int ENERGY_W = 21;
    localparam int COL_W    = 11;
    localparam int ROW_W    = 12;
    localparam int IW_W     = 12;
    localparam int IH_W     = 13;

    // Stream bus widths.
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Energy saturation value and an upper bound on the energy an 8-bit pixel can give.
    localparam logic [ENERGY_W-1:0] ENERGY_MAX  = 21'h1FFFFF;
    localparam logic [ENERGY_W-1:0] ENERGY_PEAK = 21'd2080800;

    // Register reset values.
    localparam logic [IW_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [IH_W-1:0] HEIGHT_RESET = 13'd480;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [COL_W-1:0] col_t;
    typedef logic [ROW_W-1:0] row_t;

endpackage

// ===== src/sge_line_buf.sv =====
// Line buffer memory: one write port and one registered read port.
module sge_line_buf #(
    parameter int DEPTH  = 2048,
    parameter int DATA_W = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read-before-write: a same-address collision returns the old word.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/sobel_gradient_energy.sv =====
// A pixel's result passes through the stage 1, stage 2 and output registers to m_tvalid.
// Throughput: one pixel per cycle unless m_tready stalls the output; the line buffer
// takes one read and one write per cycle; a waiting result stalls input once st1 and st2 are full.
// Border pixels produce no result; interior pixels produce exactly one.
// Reset (aresetn low, synchronous) clears position counters, window, pipeline valids
// and sets width 640, height 480; the line buffer contents are not cleared.
module sobel_gradient_energy #(
    parameter int MAX_WIDTH = sge_pkg::DEF_MAX_WIDTH,
    parameter int LUMA_BITS = sge_pkg::DEF_LUMA_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Pixel input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sge_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] luma
    input  logic                           s_tuser,   // [0] frame_start
    // Energy result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sge_pkg::M_TDATA_W-1:0]  m_tdata,   // [20:0] energy, [31:21] center_col,
                                                      // [43:32] center_row, [47:44] zero
    output logic                           m_tlast,   // last_of_frame
    // Configuration writes.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sge_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sge_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sge_pkg::*;

    localparam int ELIM = (MAX_WIDTH < COL_LIMIT) ? MAX_WIDTH : COL_LIMIT;
    localparam int AW   = $clog2(ELIM);
    localparam int PXW  = (LUMA_BITS < LUMA_W) ? LUMA_BITS : LUMA_W;
    localparam int CS_W = PXW + 2;
    localparam int S_W  = PXW + 3;
    localparam int SQ_W = 2 * S_W;
    localparam int ES_W = SQ_W + 1;

    // Configuration.
    logic [IW_W-1:0] image_width_reg;
    logic [IH_W-1:0] image_height_reg;
    logic [IW_W-1:0] eff_w;
    logic [IH_W-1:0] eff_h;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IW_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (image_width_reg < IW_W'(MIN_DIM)) begin
            eff_w = IW_W'(MIN_DIM);
        end else if (image_width_reg > IW_W'(ELIM)) begin
            eff_w = IW_W'(ELIM);
        end else begin
            eff_w = image_width_reg;
        end
        if (image_height_reg < IH_W'(MIN_DIM)) begin
            eff_h = IH_W'(MIN_DIM);
        end else if (image_height_reg > IH_W'(ROW_LIMIT)) begin
            eff_h = IH_W'(ROW_LIMIT);
        end else begin
            eff_h = image_height_reg;
        end
    end

    // Pipeline flow control.
    logic st1_v_reg, st2_v_reg, out_v_reg;
    logic out_en, en2, en1, in_acc, st1_leave;

    assign out_en    = !out_v_reg || m_tready;
    assign en2       = !st2_v_reg || out_en;
    assign en1       = !st1_v_reg || en2;
    assign s_tready  = en1;
    assign in_acc    = s_tvalid && en1;
    assign st1_leave = st1_v_reg && en2;

    // Position of the incoming pixel and the counters after it.
    col_t            col_reg, col_next, cur_c;
    row_t            row_reg, row_next, cur_r;
    logic [IH_W-1:0] row_inc, row_inc2;
    logic [IW_W-1:0] col_inc;

    always_comb begin
        row_inc = {1'b0, row_reg};
        if (s_tuser) begin
            cur_c = '0;
            cur_r = '0;
        end else begin
            if ({1'b0, col_reg} >= eff_w) begin
                cur_c   = '0;
                row_inc = {1'b0, row_reg} + IH_W'(1);
            end else begin
                cur_c = col_reg;
            end
            cur_r = (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
        end

        col_inc  = {1'b0, cur_c} + IW_W'(1);
        row_inc2 = {1'b0, cur_r} + IH_W'(1);
        if (col_inc >= eff_w) begin
            col_next = '0;
            row_next = (row_inc2 >= eff_h) ? '0 : row_inc2[ROW_W-1:0];
        end else begin
            col_next = col_inc[COL_W-1:0];
            row_next = cur_r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (in_acc) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line buffer: each word holds {upper line, middle line} for one column.
    logic [PXW-1:0]   px;
    logic [2*PXW-1:0] lb_wr_data, lb_rd_data;
    logic [AW-1:0]    lb_rd_addr;

    logic [PXW-1:0]   st1_px_reg;
    logic [AW-1:0]    st1_addr_reg;
    logic             st1_emit_reg, st1_last_reg;
    col_t             st1_col_reg;
    row_t             st1_row_reg;
    logic             fwd_reg;
    logic [2*PXW-1:0] fwd_data_reg;

    logic [PXW-1:0] top, mid;

    assign px         = s_tdata[PXW-1:0];
    assign lb_rd_addr = cur_c[AW-1:0];
    assign lb_wr_data = {mid, st1_px_reg};

    sge_line_buf #(
        .DEPTH  (ELIM),
        .DATA_W (2 * PXW)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (st1_leave),
        .wr_addr (st1_addr_reg),
        .wr_data (lb_wr_data),
        .rd_en   (in_acc),
        .rd_addr (lb_rd_addr),
        .rd_data (lb_rd_data)
    );

    // The previous pixel's column write lands on the edge this one is read,
    // so a same-column request takes the written word directly.
    assign {top, mid} = fwd_reg ? fwd_data_reg : lb_rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_v_reg <= 1'b0;
        end else if (en1) begin
            st1_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            st1_px_reg   <= px;
            st1_addr_reg <= cur_c[AW-1:0];
            st1_emit_reg <= (cur_c >= COL_W'(2)) && (cur_r >= ROW_W'(2));
            st1_last_reg <= ({1'b0, cur_c} == eff_w - IW_W'(1)) &&
                            ({1'b0, cur_r} == eff_h - IH_W'(1));
            st1_col_reg  <= cur_c - COL_W'(1);
            st1_row_reg  <= cur_r - ROW_W'(1);
            fwd_reg      <= st1_leave && (st1_addr_reg == lb_rd_addr);
            fwd_data_reg <= lb_wr_data;
        end
    end

    // 3x3 window: w0..w2 left column (top, mid, bottom), w3..w5 center column.
    logic [PXW-1:0] win_reg [6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (st1_leave) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= st1_px_reg;
        end
    end

    // Sobel responses.
    logic [CS_W-1:0]       sum_l, sum_r, sum_t, sum_b;
    logic signed [S_W-1:0] sx, sy;

    always_comb begin
        sum_l = CS_W'(win_reg[0]) + (CS_W'(win_reg[1]) << 1) + CS_W'(win_reg[2]);
        sum_r = CS_W'(top) + (CS_W'(mid) << 1) + CS_W'(st1_px_reg);
        sum_t = CS_W'(win_reg[0]) + (CS_W'(win_reg[3]) << 1) + CS_W'(top);
        sum_b = CS_W'(win_reg[2]) + (CS_W'(win_reg[5]) << 1) + CS_W'(st1_px_reg);
        sx    = $signed({1'b0, sum_l}) - $signed({1'b0, sum_r});
        sy    = $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
    end

    logic signed [S_W-1:0] st2_sx_reg, st2_sy_reg;
    col_t                  st2_col_reg;
    row_t                  st2_row_reg;
    logic                  st2_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_v_reg <= 1'b0;
        end else if (en2) begin
            st2_v_reg <= st1_v_reg && st1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_leave && st1_emit_reg) begin
            st2_sx_reg   <= sx;
            st2_sy_reg   <= sy;
            st2_col_reg  <= st1_col_reg;
            st2_row_reg  <= st1_row_reg;
            st2_last_reg <= st1_last_reg;
        end
    end

    // Squares, sum and saturation into the output register.
    logic signed [SQ_W-1:0] sq_x, sq_y;
    logic [ES_W-1:0]        esum;
    logic [ENERGY_W-1:0]    energy;

    always_comb begin
        sq_x   = st2_sx_reg * st2_sx_reg;
        sq_y   = st2_sy_reg * st2_sy_reg;
        esum   = ES_W'($unsigned(sq_x)) + ES_W'($unsigned(sq_y));
        energy = (32'(esum) > 32'(ENERGY_MAX)) ? ENERGY_MAX : ENERGY_W'(esum);
    end

    logic [ENERGY_W-1:0] out_energy_reg;
    col_t                out_col_reg;
    row_t                out_row_reg;
    logic                out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (out_en) begin
            out_v_reg <= st2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en && st2_v_reg) begin
            out_energy_reg <= energy;
            out_col_reg    <= st2_col_reg;
            out_row_reg    <= st2_row_reg;
            out_last_reg   <= st2_last_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {(M_TDATA_W - ENERGY_W - COL_W - ROW_W)'(0),
                       out_row_reg, out_col_reg, out_energy_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/sge_checker.sv =====
// Port-level checks for the Sobel gradient energy block, bound to the top level.
module sge_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sge_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tlast
);
    import sge_pkg::*;

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // An empty output register always lets a new request in.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

    // Results only come from interior pixels.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:21] != 11'd0 && m_tdata[43:32] != 12'd0)
        else $error("result on a border position");

    // Energy never exceeds the bound set by two Sobel responses of largest magnitude.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[20:0] <= ENERGY_PEAK)
        else $error("energy out of range");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind sobel_gradient_energy sge_checker u_sge_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
